[sv/eti_pkg.sv]
// Package for the eased tween interpolator: shared widths, register indexes,
// easing and loop-mode codes, and the fixed-point helpers used to build the curve table.
// No dependencies.
package eti_pkg;

  localparam int FRACTION_BITS_DEF        = 16;
  localparam int LOGISTIC_ENTRIES_DEF     = 256;

  localparam int LVL_W      = 32;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int EASE_W     = 3;
  localparam int LOOP_W     = 2;
  localparam int MUL_A_W    = 34;

  localparam logic [CFG_IDX_W-1:0] REG_FROM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 3'd5;

  localparam logic [EASE_W-1:0] EASE_NONE     = 3'd0;
  localparam logic [EASE_W-1:0] EASE_LINEAR   = 3'd1;
  localparam logic [EASE_W-1:0] EASE_QUAD_IN  = 3'd2;
  localparam logic [EASE_W-1:0] EASE_QUAD_OUT = 3'd3;
  localparam logic [EASE_W-1:0] EASE_LOGISTIC = 3'd4;

  localparam logic [LOOP_W-1:0] LOOP_ONCE      = 2'd0;
  localparam logic [LOOP_W-1:0] LOOP_OSCILLATE = 2'd1;
  localparam logic [LOOP_W-1:0] LOOP_REPEAT    = 2'd2;

  localparam logic [63:0] Q31_ONE = 64'd1 << 31;

  // Shift-and-subtract quotient of two 64-bit values, used only while building tables.
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Truncated Taylor sum of e^r through the r^24 term, Q31 in and out.
  function automatic logic [63:0] exp_pos_q31(logic [63:0] r);
    logic [63:0] term;
    logic [63:0] sum;
    term = Q31_ONE;
    sum  = Q31_ONE;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * r) >> 31, 64'(n));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] exp_neg_q31(logic [63:0] r);
    logic [63:0] s;
    s = exp_pos_q31(r);
    return udiv64(64'd1 << 62, s);
  endfunction

  function automatic logic [TICK_W-1:0] sat_add(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TICK_W] ? {TICK_W{1'b1}} : s[TICK_W-1:0];
  endfunction

endpackage

[sv/eti_divider.sv]
// Radix-2 restoring divider producing one quotient bit per cycle.
// Computes floor(num * 2^Q_W / den) for num < den. Uses eti_pkg.
module eti_divider #(
  parameter int Q_W = eti_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [eti_pkg::TICK_W-1:0] num,
  input  logic [eti_pkg::TICK_W-1:0] den,
  output logic [Q_W-1:0]            quot,
  output logic                      done
);
  import eti_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [TICK_W-1:0] rem_r;
  logic [TICK_W-1:0] den_r;
  logic [Q_W-1:0]    quot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [TICK_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        den_r  <= den;
        quot_r <= '0;
        cnt_r  <= CNT_W'(Q_W);
        run_r  <= 1'b1;
      end else if (run_r) begin
        rem_r  <= fits ? TICK_W'(shifted - {1'b0, den_r}) : shifted[TICK_W-1:0];
        quot_r <= {quot_r[Q_W-2:0], fits};
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

[sv/eti_mult.sv]
// Shared signed-by-unsigned multiplier with a registered product.
// Serves the easing curves, the table blend and the final level blend. Uses eti_pkg.
module eti_mult #(
  parameter int B_W = eti_pkg::FRACTION_BITS_DEF + 1
) (
  input  logic                               clk,
  input  logic signed [eti_pkg::MUL_A_W-1:0] op_a,
  input  logic        [B_W-1:0]              op_b,
  output logic signed [eti_pkg::MUL_A_W+B_W:0] prod
);
  import eti_pkg::*;

  logic signed [MUL_A_W+B_W:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * $signed({1'b0, op_b});
  end

  assign prod = prod_r;

endmodule

[sv/eti_logistic_rom.sv]
// Logistic curve table 1/(1+e^(5-10p)) with a registered read port.
// The table is built at elaboration from the Q31 exponential in eti_pkg.
module eti_logistic_rom #(
  parameter int FRACTION_BITS          = eti_pkg::FRACTION_BITS_DEF,
  parameter int LOGISTIC_TABLE_ENTRIES = eti_pkg::LOGISTIC_ENTRIES_DEF
) (
  input  logic                                        clk,
  input  logic [$clog2(LOGISTIC_TABLE_ENTRIES+1)-1:0] addr,
  output logic [FRACTION_BITS:0]                      data
);
  import eti_pkg::*;

  localparam int IW = $clog2(LOGISTIC_TABLE_ENTRIES + 1);

  typedef logic [FRACTION_BITS:0] tab_t [LOGISTIC_TABLE_ENTRIES+1];

  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] einv;
    logic [63:0] mag;
    logic [63:0] tq;
    logic [63:0] k;
    logic [63:0] u;
    logic [63:0] numer;
    logic        nonneg;
    einv = exp_neg_q31(Q31_ONE);
    for (int i = 0; i <= LOGISTIC_TABLE_ENTRIES; i++) begin
      nonneg = (10 * i <= 5 * LOGISTIC_TABLE_ENTRIES);
      mag    = nonneg ? 64'(5 * LOGISTIC_TABLE_ENTRIES - 10 * i)
                      : 64'(10 * i - 5 * LOGISTIC_TABLE_ENTRIES);
      tq     = udiv64(mag << 31, 64'(LOGISTIC_TABLE_ENTRIES));
      k      = tq >> 31;
      u      = exp_neg_q31(tq & (Q31_ONE - 64'd1));
      for (int j = 0; j < int'(k); j++) begin
        u = (u * einv) >> 31;
      end
      numer = nonneg ? u : Q31_ONE;
      t[i]  = (FRACTION_BITS+1)'(udiv64(numer << FRACTION_BITS, Q31_ONE + u));
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [FRACTION_BITS:0] data_r;

  always_ff @(posedge clk) begin
    if (addr > IW'(LOGISTIC_TABLE_ENTRIES)) begin
      data_r <= TAB[LOGISTIC_TABLE_ENTRIES];
    end else begin
      data_r <= TAB[addr];
    end
  end

  assign data = data_r;

endmodule

[sv/eased_tween_interpolator_top.sv]
// Eased tween interpolator: each tick transfer yields one Q16.16 level transfer.
// Uses eti_pkg, eti_divider, eti_mult and eti_logistic_rom.
//
// A tick inside the animation window passes through S_EVAL and the radix-2 divider S_DIV,
// which forms the progress fraction one bit per cycle, followed by one to three passes
// through the shared multiplier: linear easing takes the shortest path, the quadratic curves
// add S_EMUL, and the logistic curve adds S_EMUL, S_LRDB, S_LMUL and S_LFIN; all then pass
// S_BLEND, S_BFIN, S_FIN and S_PUT. A tick at or outside a window edge, or with easing off,
// goes from S_EVAL through S_FIN to S_PUT, and a tick after a run-once animation has
// finished goes from S_EVAL straight to S_PUT. One tick is in work at a time and in_stall
// is high until its result is placed in the output register, so a stalled level transfer
// holds the tick in S_PUT, and the next tick can be taken in the cycle after the result is placed.
module eased_tween_interpolator_top #(
  parameter int FRACTION_BITS          = eti_pkg::FRACTION_BITS_DEF,
  parameter int LOGISTIC_TABLE_ENTRIES = eti_pkg::LOGISTIC_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [eti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eti_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [eti_pkg::TICK_W-1:0]     in_now_tick,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [eti_pkg::LVL_W-1:0] out_level_out,
  output logic                           out_level_written,
  output logic                           out_finished_now,
  output logic                           out_cycle_restarted
);
  import eti_pkg::*;

  localparam int FB   = FRACTION_BITS;
  localparam int MB_W = FB + 1;
  localparam int PW   = MUL_A_W + MB_W + 1;
  localparam int IW   = $clog2(LOGISTIC_TABLE_ENTRIES + 1);
  localparam logic [MB_W-1:0] ONE = MB_W'(1) << FB;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_EASE  = 4'd3;
  localparam logic [3:0] S_EMUL  = 4'd4;
  localparam logic [3:0] S_LRDB  = 4'd5;
  localparam logic [3:0] S_LMUL  = 4'd6;
  localparam logic [3:0] S_LFIN  = 4'd7;
  localparam logic [3:0] S_BLEND = 4'd8;
  localparam logic [3:0] S_BFIN  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_PUT   = 4'd11;

  logic [3:0]        state_r;
  logic [LVL_W-1:0]  from_cfg_r;
  logic [LVL_W-1:0]  to_cfg_r;
  logic [TICK_W-1:0] begin_cfg_r;
  logic [TICK_W-1:0] finish_cfg_r;
  logic [EASE_W-1:0] ease_r;
  logic [LOOP_W-1:0] loop_r;
  logic [LVL_W-1:0]  cur_from_r;
  logic [LVL_W-1:0]  cur_to_r;
  logic [TICK_W-1:0] cur_begin_r;
  logic [TICK_W-1:0] cur_finish_r;
  logic              done_r;
  logic              pending_r;
  logic [TICK_W-1:0] now_r;
  logic [LVL_W-1:0]  lvl_r;
  logic              written_r;
  logic              finished_r;
  logic              restarted_r;
  logic [MB_W-1:0]   ease_val_r;
  logic [FB-1:0]     frac_r;
  logic [IW-1:0]     idx_r;
  logic [MB_W-1:0]   tab_a_r;
  logic              neg_r;
  logic              out_valid_r;
  logic [LVL_W-1:0]  out_level_r;
  logic              out_written_r;
  logic              out_finished_r;
  logic              out_restarted_r;

  logic                      in_take;
  logic                      out_free;
  logic                      ease_off;
  logic                      at_to;
  logic                      at_from;
  logic                      go_div;
  logic                      div_start;
  logic                      div_done;
  logic [FB-1:0]             quot;
  logic [MB_W-1:0]           gap;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MB_W-1:0]           mul_b;
  logic signed [PW-1:0]      prod;
  logic signed [PW-1:0]      blend_sh;
  logic [MB_W-1:0]           prod_sh;
  logic [IW-1:0]             idx_raw;
  logic [IW-1:0]             idx_clamp;
  logic [IW-1:0]             rom_addr;
  logic [MB_W-1:0]           rom_q;
  logic [MB_W-1:0]           tab_d;
  logic signed [MUL_A_W-1:0] diff;
  logic [TICK_W-1:0]         dur;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  assign ease_off = (ease_r == EASE_NONE) || (ease_r > EASE_LOGISTIC);
  assign at_to    = ease_off || (now_r >= cur_finish_r) || (cur_finish_r <= cur_begin_r);
  assign at_from  = now_r <= cur_begin_r;
  assign go_div   = !done_r && !at_to && !at_from;
  assign div_start = (state_r == S_EVAL) && go_div;

  assign gap       = ONE - MB_W'(quot);
  assign prod_sh   = prod[FB +: MB_W];
  assign idx_raw   = prod[FB +: IW];
  assign idx_clamp = (idx_raw >= IW'(LOGISTIC_TABLE_ENTRIES))
                     ? IW'(LOGISTIC_TABLE_ENTRIES - 1) : idx_raw;
  assign rom_addr  = (state_r == S_EMUL) ? idx_clamp : idx_r + IW'(1);
  assign tab_d     = (rom_q >= tab_a_r) ? rom_q - tab_a_r : tab_a_r - rom_q;
  assign diff      = MUL_A_W'($signed(cur_to_r)) - MUL_A_W'($signed(cur_from_r));
  assign blend_sh  = prod >>> FB;
  assign dur       = (cur_finish_r > cur_begin_r) ? cur_finish_r - cur_begin_r : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_EASE: begin
        case (ease_r)
          EASE_QUAD_IN: begin
            mul_a = MUL_A_W'(quot);
            mul_b = MB_W'(quot);
          end
          EASE_QUAD_OUT: begin
            mul_a = MUL_A_W'(gap);
            mul_b = gap;
          end
          EASE_LOGISTIC: begin
            mul_a = MUL_A_W'(LOGISTIC_TABLE_ENTRIES);
            mul_b = MB_W'(quot);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      S_LMUL: begin
        mul_a = MUL_A_W'(tab_d);
        mul_b = MB_W'(frac_r);
      end
      S_BLEND: begin
        mul_a = diff;
        mul_b = ease_val_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  eti_divider #(
    .Q_W (FB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (now_r - cur_begin_r),
    .den   (cur_finish_r - cur_begin_r),
    .quot  (quot),
    .done  (div_done)
  );

  eti_mult #(
    .B_W (MB_W)
  ) u_mult (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  eti_logistic_rom #(
    .FRACTION_BITS          (FRACTION_BITS),
    .LOGISTIC_TABLE_ENTRIES (LOGISTIC_TABLE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      from_cfg_r   <= '0;
      to_cfg_r     <= '0;
      begin_cfg_r  <= '0;
      finish_cfg_r <= '0;
      ease_r       <= EASE_LINEAR;
      loop_r       <= LOOP_ONCE;
      done_r       <= 1'b0;
      pending_r    <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_PUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            now_r <= in_now_tick;
            if (pending_r) begin
              cur_from_r <= from_cfg_r;
              cur_to_r   <= to_cfg_r;
              if (begin_cfg_r == '0) begin
                cur_begin_r  <= in_now_tick;
                cur_finish_r <= sat_add(in_now_tick, finish_cfg_r);
              end else begin
                cur_begin_r  <= begin_cfg_r;
                cur_finish_r <= finish_cfg_r;
              end
              done_r    <= 1'b0;
              pending_r <= 1'b0;
            end
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          written_r   <= 1'b0;
          finished_r  <= 1'b0;
          restarted_r <= 1'b0;
          if (done_r) begin
            lvl_r   <= cur_to_r;
            state_r <= S_PUT;
          end else if (at_to) begin
            lvl_r   <= cur_to_r;
            state_r <= S_FIN;
          end else if (at_from) begin
            lvl_r   <= cur_from_r;
            state_r <= S_FIN;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_EASE;
          end
        end
        S_EASE: begin
          if (ease_r == EASE_LINEAR) begin
            ease_val_r <= MB_W'(quot);
            state_r    <= S_BLEND;
          end else begin
            state_r <= S_EMUL;
          end
        end
        S_EMUL: begin
          case (ease_r)
            EASE_QUAD_IN: begin
              ease_val_r <= prod_sh;
              state_r    <= S_BLEND;
            end
            EASE_QUAD_OUT: begin
              ease_val_r <= ONE - prod_sh;
              state_r    <= S_BLEND;
            end
            default: begin
              idx_r   <= idx_clamp;
              frac_r  <= prod[FB-1:0];
              state_r <= S_LRDB;
            end
          endcase
        end
        S_LRDB: begin
          tab_a_r <= rom_q;
          state_r <= S_LMUL;
        end
        S_LMUL: begin
          neg_r   <= rom_q < tab_a_r;
          state_r <= S_LFIN;
        end
        S_LFIN: begin
          ease_val_r <= neg_r ? tab_a_r - prod_sh : tab_a_r + prod_sh;
          state_r    <= S_BLEND;
        end
        S_BLEND: begin
          state_r <= S_BFIN;
        end
        S_BFIN: begin
          lvl_r   <= cur_from_r + blend_sh[LVL_W-1:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          written_r <= 1'b1;
          if (lvl_r == cur_to_r) begin
            case (loop_r) inside
              LOOP_OSCILLATE, LOOP_REPEAT: begin
                if (loop_r == LOOP_OSCILLATE) begin
                  cur_from_r <= cur_to_r;
                  cur_to_r   <= cur_from_r;
                end
                cur_finish_r <= sat_add(now_r, dur);
                cur_begin_r  <= now_r;
                restarted_r  <= 1'b1;
              end
              default: begin
                done_r     <= 1'b1;
                finished_r <= 1'b1;
              end
            endcase
          end
          state_r <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_level_r     <= lvl_r;
            out_written_r   <= written_r;
            out_finished_r  <= finished_r;
            out_restarted_r <= restarted_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_FROM: begin
            from_cfg_r <= cfg_wdata[LVL_W-1:0];
            pending_r  <= 1'b1;
            done_r     <= 1'b0;
          end
          REG_TO: begin
            to_cfg_r  <= cfg_wdata[LVL_W-1:0];
            pending_r <= 1'b1;
            done_r    <= 1'b0;
          end
          REG_BEGIN: begin
            begin_cfg_r <= cfg_wdata[TICK_W-1:0];
            pending_r   <= 1'b1;
            done_r      <= 1'b0;
          end
          REG_FINISH: begin
            finish_cfg_r <= cfg_wdata[TICK_W-1:0];
            pending_r    <= 1'b1;
            done_r       <= 1'b0;
          end
          REG_EASE: begin
            ease_r <= cfg_wdata[EASE_W-1:0];
          end
          REG_LOOP: begin
            loop_r <= cfg_wdata[LOOP_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_level_out       = $signed(out_level_r);
  assign out_level_written   = out_written_r;
  assign out_finished_now    = out_finished_r;
  assign out_cycle_restarted = out_restarted_r;

endmodule

[dv/eased_tween_interpolator_top_test.sv]
// Self-checking test of eased_tween_interpolator_top: tick transfers are predicted by a
// scoreboard class and each level transfer is compared with the oldest prediction.
// Depends on eti_pkg and the eased_tween_interpolator_top RTL.
module eased_tween_interpolator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import eti_pkg::*;

  localparam int FB = FRACTION_BITS_DEF;
  localparam int NPTS = LOGISTIC_ENTRIES_DEF;
  localparam logic [63:0] Q31_UNIT = 64'd1 << 31;
  localparam logic [63:0] FB_UNIT = 64'd1 << FB;
  localparam int ITEM_TARGET = 1950;
  localparam int RUN_LIMIT = 1000000;
  localparam logic [EASE_W-1:0] EASE_UNUSED_LO = 3'd5;
  localparam logic [EASE_W-1:0] EASE_UNUSED_HI = 3'd7;
  localparam logic [LOOP_W-1:0] LOOP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [LVL_W-1:0] level;
    logic written;
    logic finished;
    logic restarted;
  } level_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TICK_W-1:0] in_now_tick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [LVL_W-1:0] out_level_out;
  logic out_level_written;
  logic out_finished_now;
  logic out_cycle_restarted;

  eased_tween_interpolator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_now_tick(in_now_tick),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_level_out(out_level_out),
    .out_level_written(out_level_written),
    .out_finished_now(out_finished_now),
    .out_cycle_restarted(out_cycle_restarted)
  );

  class tween_scoreboard;
    logic [31:0] from_reg, to_reg, begin_reg, finish_reg;
    logic [EASE_W-1:0] ease_reg;
    logic [LOOP_W-1:0] loop_reg;
    logic [31:0] cur_from, cur_to, cur_begin, cur_finish;
    bit done;
    bit rearm;
    logic [63:0] curve_pts[NPTS+1];
    level_result_t awaited[$];
    int unsigned mismatches, completions, restarts, held;

    function new();
      logic [63:0] einv, mag, t, u;
      bit nonneg;
      from_reg = '0;
      to_reg = '0;
      begin_reg = '0;
      finish_reg = '0;
      ease_reg = EASE_LINEAR;
      loop_reg = LOOP_ONCE;
      cur_from = '0;
      cur_to = '0;
      cur_begin = '0;
      cur_finish = '0;
      done = 1'b0;
      rearm = 1'b1;
      einv = exp_minus(Q31_UNIT);
      for (int i = 0; i <= NPTS; i++) begin
        nonneg = (10 * i <= 5 * NPTS);
        mag = nonneg ? 64'(5 * NPTS - 10 * i) : 64'(10 * i - 5 * NPTS);
        t = (mag << 31) / 64'(NPTS);
        u = exp_minus(t & (Q31_UNIT - 1));
        for (int j = 0; j < int'(t >> 31); j++) u = (u * einv) >> 31;
        curve_pts[i] = ((nonneg ? u : Q31_UNIT) << FB) / (Q31_UNIT + u);
      end
    endfunction

    function logic [63:0] exp_minus(logic [63:0] r);
      logic [63:0] term, series;
      term = Q31_UNIT;
      series = Q31_UNIT;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * r) >> 31) / 64'(n);
        series = series + term;
      end
      return (64'd1 << 62) / series;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
    endfunction

    function logic [63:0] shape(logic [63:0] p);
      logic [63:0] g, pos, idx, rem, a, b;
      case (ease_reg)
        EASE_QUAD_IN: return (p * p) >> FB;
        EASE_QUAD_OUT: begin
          g = FB_UNIT - p;
          return FB_UNIT - ((g * g) >> FB);
        end
        EASE_LOGISTIC: begin
          pos = p * 64'(NPTS);
          idx = pos >> FB;
          if (idx >= 64'(NPTS)) idx = 64'(NPTS - 1);
          rem = pos & (FB_UNIT - 1);
          a = curve_pts[idx];
          b = curve_pts[idx + 1];
          if (b >= a) return a + (((b - a) * rem) >> FB);
          return a - (((a - b) * rem) >> FB);
        end
        default: return p;
      endcase
    endfunction

    function logic [31:0] level_at(logic [31:0] now);
      logic [63:0] p;
      longint diff, prod, sum;
      if (ease_reg == EASE_NONE || ease_reg > EASE_LOGISTIC) return cur_to;
      if (now >= cur_finish || cur_finish <= cur_begin) return cur_to;
      if (now <= cur_begin) return cur_from;
      p = ({32'd0, now - cur_begin} << FB) / {32'd0, cur_finish - cur_begin};
      diff = longint'($signed(cur_to)) - longint'($signed(cur_from));
      prod = diff * longint'(shape(p));
      sum = longint'($signed(cur_from)) + (prod >>> FB);
      return 32'(sum);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FROM: from_reg = data;
        REG_TO: to_reg = data;
        REG_BEGIN: begin_reg = data;
        REG_FINISH: finish_reg = data;
        REG_EASE: ease_reg = data[EASE_W-1:0];
        REG_LOOP: loop_reg = data[LOOP_W-1:0];
        default: ;
      endcase
      if (idx == REG_FROM || idx == REG_TO || idx == REG_BEGIN || idx == REG_FINISH) begin
        rearm = 1'b1;
        done = 1'b0;
      end
    endfunction

    function void note_tick(logic [31:0] now);
      level_result_t r;
      logic [31:0] span, swap;
      r = '0;
      if (rearm) begin
        cur_from = from_reg;
        cur_to = to_reg;
        if (begin_reg == 0) begin
          cur_begin = now;
          cur_finish = sat_sum(now, finish_reg);
        end else begin
          cur_begin = begin_reg;
          cur_finish = finish_reg;
        end
        done = 1'b0;
        rearm = 1'b0;
      end
      if (done) begin
        r.level = cur_to;
        held++;
      end else begin
        r.level = level_at(now);
        r.written = 1'b1;
        if (r.level == cur_to) begin
          if (loop_reg == LOOP_OSCILLATE || loop_reg == LOOP_REPEAT) begin
            if (loop_reg == LOOP_OSCILLATE) begin
              swap = cur_from;
              cur_from = cur_to;
              cur_to = swap;
            end
            span = (cur_finish > cur_begin) ? cur_finish - cur_begin : 32'd0;
            cur_finish = sat_sum(now, span);
            cur_begin = now;
            r.restarted = 1'b1;
            restarts++;
          end else begin
            done = 1'b1;
            r.finished = 1'b1;
            completions++;
          end
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_level(level_result_t got);
      level_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: level transfer with none outstanding: level %h wr %b fin %b rst %b",
                   got.level, got.written, got.finished, got.restarted);
        return;
      end
      want = awaited.pop_front();
      if (got.level !== want.level || got.written !== want.written ||
          got.finished !== want.finished || got.restarted !== want.restarted) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected level %h wr %b fin %b rst %b, got level %h wr %b fin %b rst %b",
                   want.level, want.written, want.finished, want.restarted,
                   got.level, got.written, got.finished, got.restarted);
      end
    endfunction
  endclass

  tween_scoreboard tracker = new();
  bit calm;
  int unsigned cycle_count;
  int unsigned ticks_sent;
  int unsigned settings;
  logic [31:0] last_tick;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("eased_tween_interpolator_top test failed");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 37);

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_tick(in_now_tick);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_level(level_result_t'({out_level_out, out_level_written,
                                            out_finished_now, out_cycle_restarted}));
  end

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_tick(logic [31:0] t);
    if (!calm) begin
      while ($urandom_range(0, 99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_now_tick <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_tick = t;
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    settings++;
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 9)) inside
      5, 6, 7: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      8: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_ease();
    logic [EASE_W-1:0] code;
    case ($urandom_range(0, 19)) inside
      0: code = EASE_NONE;
      1: code = 3'($urandom_range(EASE_UNUSED_LO, EASE_UNUSED_HI));
      2, 6, 10, 14, 18: code = EASE_LINEAR;
      3, 7, 11, 15: code = EASE_QUAD_IN;
      4, 8, 12, 16: code = EASE_QUAD_OUT;
      default: code = EASE_LOGISTIC;
    endcase
    return {($urandom_range(0, 3) == 0) ? 29'($urandom()) : 29'd0, code};
  endfunction

  function automatic logic [31:0] pick_loop();
    logic [LOOP_W-1:0] code;
    case ($urandom_range(0, 9)) inside
      0: code = LOOP_UNUSED;
      1, 2, 3: code = LOOP_ONCE;
      4, 5, 6: code = LOOP_OSCILLATE;
      default: code = LOOP_REPEAT;
    endcase
    return {($urandom_range(0, 3) == 0) ? 30'($urandom()) : 30'd0, code};
  endfunction

  initial begin
    logic [31:0] t, base, span, b, f;
    int unsigned phase;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: an empty window finishes on the first tick.
    push_tick(32'd0);
    push_tick(32'd5);
    drain();

    program_reg(REG_FROM, 32'h8000_0000);
    program_reg(REG_TO, 32'h7FFF_FFFF);
    program_reg(REG_FINISH, 32'd100);
    push_tick(32'd1000);
    push_tick(32'd1001);
    push_tick(32'd1050);
    push_tick(32'd1100);
    push_tick(32'd1200);
    drain();

    program_reg(REG_EASE, 32'(EASE_QUAD_IN));
    program_reg(REG_LOOP, 32'(LOOP_REPEAT));
    program_reg(REG_FROM, 32'h0001_0000);
    program_reg(REG_TO, 32'hFFFF_0000);
    program_reg(REG_BEGIN, 32'hFFFF_FF00);
    program_reg(REG_FINISH, 32'hFFFF_FFFF);
    push_tick(32'hFFFF_FE00);
    push_tick(32'hFFFF_FF40);
    push_tick(32'hFFFF_FFFF);
    push_tick(32'hFFFF_FFFF);
    drain();

    program_reg(REG_EASE, 32'(EASE_QUAD_OUT));
    program_reg(REG_LOOP, 32'(LOOP_OSCILLATE));
    program_reg(REG_BEGIN, 32'd0);
    program_reg(REG_FINISH, 32'hFFFF_FFF0);
    push_tick(32'h0000_0020);
    push_tick(32'h7FFF_FFFF);
    push_tick(32'hFFFF_FFFF);
    drain();

    program_reg(REG_EASE, 32'(EASE_LOGISTIC));
    program_reg(REG_LOOP, {30'h3FFF_FFFF, LOOP_UNUSED});
    program_reg(REG_BEGIN, 32'd50);
    program_reg(REG_FINISH, 32'd30);
    push_tick(32'd40);
    drain();
    program_reg(REG_BEGIN, 32'd100);
    program_reg(REG_FINISH, 32'd356);
    push_tick(32'd150);
    push_tick(32'd228);
    push_tick(32'd300);
    push_tick(32'd356);
    drain();

    program_reg(REG_SPARE_LO, $urandom());
    program_reg(REG_SPARE_HI, $urandom());
    program_reg(REG_EASE, {29'h1FFF_FFFF, EASE_NONE});
    program_reg(REG_LOOP, 32'(LOOP_ONCE));
    program_reg(REG_BEGIN, 32'd0);
    program_reg(REG_FINISH, 32'd1000);
    push_tick(32'd10);
    push_tick(32'd20);
    drain();
    program_reg(REG_EASE, 32'(EASE_UNUSED_LO));
    program_reg(REG_TO, 32'h1234_5678);
    push_tick(32'd30);
    drain();

    span = 32'd100;
    phase = 0;
    while (ticks_sent < ITEM_TARGET) begin
      phase++;
      calm = (phase >= 12 && phase < 24);
      if ($urandom_range(0, 4) == 0) begin
        // Easing and loop changes take effect without restarting the animation.
        program_reg(REG_EASE, pick_ease());
        if ($urandom_range(0, 1) == 0) program_reg(REG_LOOP, pick_loop());
        t = last_tick;
      end else begin
        program_reg(REG_FROM, pick_level());
        program_reg(REG_TO, pick_level());
        program_reg(REG_EASE, pick_ease());
        program_reg(REG_LOOP, pick_loop());
        case ($urandom_range(0, 9))
          0: base = $urandom();
          1: base = 32'hFFFF_FFFF - 32'($urandom_range(0, 400));
          default: base = last_tick + 32'($urandom_range(0, 50));
        endcase
        span = ($urandom_range(0, 11) == 0) ? $urandom() : 32'($urandom_range(1, 300));
        if ($urandom_range(0, 2) == 0) begin
          program_reg(REG_BEGIN, 32'd0);
          program_reg(REG_FINISH, span);
        end else begin
          b = base + 32'($urandom_range(1, 30));
          f = ($urandom_range(0, 9) == 0) ? b - 32'($urandom_range(0, 20)) : b + span;
          program_reg(REG_BEGIN, b);
          program_reg(REG_FINISH, f);
        end
        t = base;
      end
      repeat ($urandom_range(6, 50)) begin
        if ($urandom_range(0, 29) == 0) t = $urandom();
        else t = t + 32'($urandom_range(0, span / 8 + 1));
        push_tick(t);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Covered %0d tick transfers over %0d settings: %0d run-once completions,",
             ticks_sent, settings, tracker.completions);
    $display("%0d window restarts and %0d levels held after completion.",
             tracker.restarts, tracker.held);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("eased_tween_interpolator_top test passed");
    end else begin
      $display("eased_tween_interpolator_top test failed");
    end
    $finish;
  end

endmodule
